>>> src/rice_posting_list_decoder_unit_defines.svh
// Assertion macros used by the seen bitmap source of the posting list decoder.
`ifndef RICE_POSTING_LIST_DECODER_UNIT_DEFINES_SVH
`define RICE_POSTING_LIST_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define RPLD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define RPLD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPLD_ASSERT(label, prop, msg)
`define RPLD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> src/rpld_pkg.sv
// Shared constants, types and helper functions of the posting list decoder.
package rpld_pkg;

	// Default width of a file id and of the seen bitmap address.
	localparam int ID_BITS_DEF = 16;

	// Register reset values and limits.
	localparam logic [3:0]  RICE_K_RESET     = 4'd4;
	localparam logic [3:0]  K_MAX            = 4'd8;
	localparam logic [16:0] FILE_COUNT_RESET = 17'h10000;

	// Quotient accumulation.
	localparam int          QUOT_W   = 16;
	localparam logic [15:0] QUOT_MAX = 16'hFFFF;
	localparam logic [15:0] RUN_STEP = 16'd8;
	localparam logic [7:0]  BYTE_RUN = 8'hFF;

	// Bitmap memory rows hold 2**ROW_LG flags each.
	localparam int ROW_LG = 6;

	// Configuration port.
	localparam int APB_AW = 3;
	localparam logic REG_RICE_K     = 1'b0;
	localparam logic REG_FILE_COUNT = 1'b1;

	// Operation codes of an input transaction.
	localparam logic OP_POST  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Control handed from the decoder to the bitmap stage.
	typedef struct packed {
		logic probe;
		logic clear;
	} lookup_t;

	// Number of leading ones of a byte that is not all ones.
	function automatic logic [2:0] lead_ones(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		priority casez (b)
			8'b0???????: n = 3'd0;
			8'b10??????: n = 3'd1;
			8'b110?????: n = 3'd2;
			8'b1110????: n = 3'd3;
			8'b11110???: n = 3'd4;
			8'b111110??: n = 3'd5;
			8'b1111110?: n = 3'd6;
			default:     n = 3'd7;
		endcase
		return n;
	endfunction

	// Saturating 16-bit add.
	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? QUOT_MAX : s[15:0];
	endfunction

endpackage

>>> src/rpld_post_if.sv
// Channel that carries posting bytes and clear requests into the decoder.
interface rpld_post_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] code_byte;
	logic       list_last;

	modport source(output valid, op, code_byte, list_last, input ready);
	modport sink(input valid, op, code_byte, list_last, output ready);
endinterface

>>> src/rpld_hit_if.sv
// Channel that carries newly seen file ids out of the decoder.
interface rpld_hit_if;
	logic        valid;
	logic        ready;
	logic [15:0] file_id;

	modport source(output valid, file_id, input ready);
	modport sink(input valid, file_id, output ready);
endinterface

>>> src/rpld_cfg.sv
// APB configuration registers: Rice parameter and file count.
module rpld_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpld_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [3:0]                  rice_k,
	output logic [16:0]                 file_count
);

	logic [3:0]  rice_k_q;
	logic [16:0] file_count_q;
	logic        reg_sel;
	logic        wr_en;

	// The register index is the word address.
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes at the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rice_k_q     <= rpld_pkg::RICE_K_RESET;
			file_count_q <= rpld_pkg::FILE_COUNT_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				rpld_pkg::REG_RICE_K:     rice_k_q     <= pwdata[3:0];
				rpld_pkg::REG_FILE_COUNT: file_count_q <= pwdata[16:0];
				default:                  rice_k_q     <= rice_k_q;
			endcase
		end
	end

	// Read back.
	always_comb begin
		unique case (reg_sel)
			rpld_pkg::REG_RICE_K:     prdata = {28'd0, rice_k_q};
			rpld_pkg::REG_FILE_COUNT: prdata = {15'd0, file_count_q};
			default:                  prdata = 32'd0;
		endcase
	end

	assign rice_k     = rice_k_q;
	assign file_count = file_count_q;

endmodule

>>> src/rpld_decode.sv
// Rice code decoder: quotient gathering, delta and running id, list stop.
module rpld_decode #(
	parameter int ID_BITS = rpld_pkg::ID_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  op,
	input  logic [7:0]            code_byte,
	input  logic                  list_last,
	input  logic [3:0]            rice_k,
	input  logic [16:0]           file_count,
	output rpld_pkg::lookup_t     look,
	output logic [ID_BITS-1:0]    id
);

	localparam int SUM_W = ((ID_BITS > 24) ? ID_BITS : 24) + 1;

	logic [15:0]        quot_q;
	logic [ID_BITS-1:0] running_q;
	logic               stopped_q;

	logic [3:0]       k_eff;
	logic [2:0]       ones;
	logic [7:0]       shifted;
	logic [7:0]       rem;
	logic [15:0]      quot;
	logic [23:0]      delta;
	logic [SUM_W-1:0] sum;
	logic             too_big;
	logic             is_run;
	logic             is_post;

	// Decode one byte against the list state.
	always_comb begin
		k_eff   = (rice_k > rpld_pkg::K_MAX) ? rpld_pkg::K_MAX : rice_k;
		ones    = rpld_pkg::lead_ones(code_byte);
		shifted = code_byte << ones;
		rem     = shifted >> (4'd8 - k_eff);
		quot    = rpld_pkg::sat_add(quot_q, {13'd0, ones});
		delta   = ({8'd0, quot} << k_eff) | {16'd0, rem};
		sum     = SUM_W'(running_q) + SUM_W'(delta);
		too_big = (sum >= SUM_W'(file_count)) || (|sum[SUM_W-1:ID_BITS]);
		is_run  = (code_byte == rpld_pkg::BYTE_RUN);
		is_post = (op == rpld_pkg::OP_POST);
	end

	assign look.probe = is_post && !stopped_q && !is_run && !too_big;
	assign look.clear = (op == rpld_pkg::OP_CLEAR);
	assign id         = sum[ID_BITS-1:0];

	// List state update; the last byte of a list returns it to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q    <= '0;
			running_q <= '0;
			stopped_q <= 1'b0;
		end else if (accept && is_post) begin
			if (list_last) begin
				quot_q    <= '0;
				running_q <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (is_run) begin
					quot_q <= rpld_pkg::sat_add(quot_q, rpld_pkg::RUN_STEP);
				end else begin
					quot_q <= '0;
					if (too_big) begin
						stopped_q <= 1'b1;
					end else begin
						running_q <= id;
					end
				end
			end
		end
	end

endmodule

>>> src/rpld_seen.sv
// Seen bitmap memory with read-modify-write, clearing pass and output register.
`include "rice_posting_list_decoder_unit_defines.svh"

module rpld_seen #(
	parameter int ID_BITS = rpld_pkg::ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  rpld_pkg::lookup_t  look,
	input  logic [ID_BITS-1:0] id,
	output logic               ready,
	rpld_hit_if.source         hits
);

	localparam int RA   = ID_BITS - rpld_pkg::ROW_LG;
	localparam int ROWS = 1 << RA;
	localparam int RW   = 1 << rpld_pkg::ROW_LG;

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_CLEAR = 2'b10
	} state_t;

	state_t state_q;
	logic [RA-1:0] clr_q;

	logic [RW-1:0] mem [ROWS];
	logic [RW-1:0] rdata_s1;

	logic               valid_s1;
	logic               probe_s1;
	logic               clear_s1;
	logic [ID_BITS-1:0] id_s1;

	logic          fwd_valid_q;
	logic [RA-1:0] fwd_row_q;
	logic [RW-1:0] fwd_data_q;

	logic          out_valid_q;
	logic [15:0]   file_id_q;

	logic                    s1_go;
	logic [RA-1:0]           row_s1;
	logic [rpld_pkg::ROW_LG-1:0] bit_s1;
	logic [RW-1:0]           cur;
	logic [RW-1:0]           wdata;
	logic                    fresh;
	logic                    wr_hit;
	logic                    rd_en;

	// Stage one advances when the output register can take its result.
	assign s1_go = valid_s1 && (!out_valid_q || hits.ready);
	assign ready = (state_q == ST_RUN) && !(valid_s1 && clear_s1) && (!valid_s1 || s1_go);
	assign rd_en = accept && look.probe;

	// Bit test on the row, taking the latest write to the same row.
	always_comb begin
		row_s1 = id_s1[ID_BITS-1:rpld_pkg::ROW_LG];
		bit_s1 = id_s1[rpld_pkg::ROW_LG-1:0];
		cur    = (fwd_valid_q && (fwd_row_q == row_s1)) ? fwd_data_q : rdata_s1;
		fresh  = !cur[bit_s1];
		wdata  = cur | (RW'(1) << bit_s1);
		wr_hit = s1_go && probe_s1 && fresh;
	end

	// Bitmap memory: one read port, one write port shared with the clearing pass.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (wr_hit) begin
			mem[row_s1] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[id[ID_BITS-1:rpld_pkg::ROW_LG]];
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			id_s1    <= id;
			probe_s1 <= look.probe;
			clear_s1 <= look.clear;
		end
		if (wr_hit) begin
			fwd_row_q  <= row_s1;
			fwd_data_q <= wdata;
		end
		if (wr_hit) begin
			file_id_q <= 16'(id_s1);
		end
	end

	// Control: stage valid, forwarding valid, output valid and clearing sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			if (wr_hit) begin
				out_valid_q <= 1'b1;
			end else if (hits.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_RUN: begin
					if (wr_hit) begin
						fwd_valid_q <= 1'b1;
					end
					if (s1_go && clear_s1) begin
						state_q     <= ST_CLEAR;
						clr_q       <= '0;
						fwd_valid_q <= 1'b0;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + RA'(1);
					if (clr_q == {RA{1'b1}}) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign hits.valid   = out_valid_q;
	assign hits.file_id = file_id_q;

	// A fresh id leaves its flag set in the forwarding register.
	`RPLD_ASSERT(a_hit_marks_row, wr_hit |=> fwd_valid_q && (fwd_data_q == $past(wdata)), "lost hit")
	// Nothing is in flight while the bitmap is swept.
	`RPLD_ASSERT(a_clear_idle, (state_q == ST_CLEAR) |-> !valid_s1 && !rd_en, "busy in clear")
	// The forwarding register never outlives a clearing pass.
	`RPLD_ASSERT(a_fwd_after_clear, (state_q == ST_CLEAR) |-> !fwd_valid_q, "stale forwarding")
	// A result only appears after a fresh lookup.
	`RPLD_ASSERT(a_out_source, $rose(out_valid_q) |-> $past(wr_hit), "result without lookup")

endmodule

>>> src/rice_posting_list_decoder_unit.sv
// Top level of the Rice-coded posting list decoder.
//
//  Channel    Direction  Transaction
//  postings   in         op, code_byte, list_last: one posting byte or a bitmap clear
//  hits       out        file_id: one newly seen file id
//  APB        in/out     register writes and reads, rice_k at 0x0, file_count at 0x4
//
// Posting bytes are taken one per cycle while ready is high; a fresh id leaves through
// one bitmap memory stage and the output register.
// After reset, and after each clear op, a clearing pass writes one bitmap row of 64
// flags per cycle over all 2**(ID_BITS-6) rows; no byte is taken then.
// A stall on hits holds the bitmap stage, and postings then takes at most one more byte.
module rice_posting_list_decoder_unit #(
	parameter int ID_BITS = rpld_pkg::ID_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rpld_post_if.sink                   postings,
	rpld_hit_if.source                  hits,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rpld_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [3:0]         rice_k;
	logic [16:0]        file_count;
	logic               accept;
	logic               ready;
	rpld_pkg::lookup_t  look;
	logic [ID_BITS-1:0] id;

	assign postings.ready = ready;
	assign accept         = postings.valid && ready;

	// Configuration registers.
	rpld_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.rice_k     (rice_k),
		.file_count (file_count)
	);

	// Code decoding and list state.
	rpld_decode #(
		.ID_BITS (ID_BITS)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (postings.op),
		.code_byte  (postings.code_byte),
		.list_last  (postings.list_last),
		.rice_k     (rice_k),
		.file_count (file_count),
		.look       (look),
		.id         (id)
	);

	// Seen bitmap and result output.
	rpld_seen #(
		.ID_BITS (ID_BITS)
	) u_seen (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.look   (look),
		.id     (id),
		.ready  (ready),
		.hits   (hits)
	);

endmodule
